[hdl/emrc_pkg.sv]
`timescale 1ns / 1ps
package emrc_pkg;

   localparam int PRESCALER_W = 15;
   localparam logic [PRESCALER_W-1:0] PRESCALER_RESET = 15'd255;

   typedef struct packed {
      logic [41:0] timestamp_ms;
      logic        write_date;
   } emrc_req_type;

   typedef struct packed {
      logic [4:0]  hours;
      logic [5:0]  minutes;
      logic [5:0]  seconds_plus_one;
      logic [14:0] shift_count;
      logic [2:0]  weekday;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [7:0]  years_since_1970;
      logic        date_valid;
   } emrc_rsp_type;

   // whole days since the epoch and the time of day in units of 1024 ms
   typedef struct packed {
      logic [15:0] days;
      logic [16:0] msd_rem;
      logic [9:0]  ms_low;
      logic        write_date;
   } emrc_days_type;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds_plus_one;
      logic [9:0] ms;
      logic [2:0] weekday;
      logic [3:0] month;
      logic [4:0] day_of_month;
      logic [7:0] years_since_1970;
      logic       write_date;
   } emrc_civ_type;

   typedef struct packed {
      emrc_civ_type civ;
      logic [14:0]  shift_count;
   } emrc_full_type;

endpackage

[hdl/emrc_divide.sv]
`timescale 1ns / 1ps
module emrc_divide import emrc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  emrc_req_type  in_beat,
   output logic          out_valid,
   input  logic          out_ready,
   output emrc_days_type out_beat
);

   localparam int STAGES = 4;
   localparam int STEPS = 4;
   localparam logic [17:0] DAY_DIV = 18'd84375;

   typedef struct packed {
      logic [16:0] rem;
      logic [15:0] dvd;
      logic [15:0] quo;
      logic [9:0]  ms_low;
      logic        write_date;
   } div_type;

   function automatic div_type day_steps(input div_type x);
      div_type     y;
      logic [17:0] trial;
      y = x;
      for (int k = 0; k < STEPS; k++) begin
         trial = {y.rem, y.dvd[15]};
         y.dvd = {y.dvd[14:0], 1'b0};
         if (trial >= DAY_DIV) begin
            trial = trial - DAY_DIV;
            y.quo = {y.quo[14:0], 1'b1};
         end else begin
            y.quo = {y.quo[14:0], 1'b0};
         end
         y.rem = trial[16:0];
      end
      return y;
   endfunction

   div_type           entry;
   div_type           up [STAGES];
   div_type           stage_in [STAGES];
   div_type           stage_ff [STAGES];
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] valid_ff;
   logic [STAGES:0]   adv;

   always_comb begin
      entry.rem        = {1'b0, in_beat.timestamp_ms[41:26]};
      entry.dvd        = in_beat.timestamp_ms[25:10];
      entry.quo        = '0;
      entry.ms_low     = in_beat.timestamp_ms[9:0];
      entry.write_date = in_beat.write_date;
   end

   assign adv[STAGES] = out_ready;

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      assign adv[s] = !valid_ff[s] || adv[s+1];
      if (s == 0) begin : g_first
         assign up[s] = entry;
      end else begin : g_next
         assign up[s] = stage_ff[s-1];
      end
      assign stage_in[s] = day_steps(up[s]);
      always_ff @(posedge clock) begin
         if (adv[s]) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign valid_in = (adv[STAGES-1:0] & {valid_ff[STAGES-2:0], in_valid})
                   | (~adv[STAGES-1:0] & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready            = adv[0];
   assign out_valid           = valid_ff[STAGES-1];
   assign out_beat.days       = stage_ff[STAGES-1].quo;
   assign out_beat.msd_rem    = stage_ff[STAGES-1].rem;
   assign out_beat.ms_low     = stage_ff[STAGES-1].ms_low;
   assign out_beat.write_date = stage_ff[STAGES-1].write_date;

   a_day_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_beat.msd_rem < DAY_DIV) && (out_beat.days <= 16'd50903))
      else $error("day split out of range");

endmodule

[hdl/emrc_civil.sv]
`timescale 1ns / 1ps
module emrc_civil import emrc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  emrc_days_type in_beat,
   output logic          out_valid,
   input  logic          out_ready,
   output emrc_civ_type  out_beat
);

   localparam logic [19:0] HOUR_DIV     = 20'd28125;
   localparam logic [16:0] MIN_DIV      = 17'd1875;
   localparam logic [12:0] SEC_DIV      = 13'd125;
   localparam logic [16:0] CYCLE_DIV    = 17'd1461;
   localparam logic [16:0] EPOCH_OFFSET = 17'd671;
   localparam logic [16:0] GAP_DAY      = 17'd48212;
   localparam logic [10:0] YEAR1_DAYS   = 11'd365;
   localparam logic [10:0] YEAR2_DAYS   = 11'd730;
   localparam logic [10:0] YEAR3_DAYS   = 11'd1095;
   localparam logic [5:0]  WEEK_SHIFT   = 6'd3;
   localparam logic [3:0]  WEEK_LEN     = 4'd7;
   localparam logic [3:0]  MP_JANUARY   = 4'd10;
   localparam logic [7:0]  YEAR_BIAS    = 8'd2;
   localparam logic [8:0]  MONTH_START [12] = '{
      9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
      9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
   };

   typedef struct packed {
      logic [4:0]  hours;
      logic [21:0] msh;
      logic [5:0]  cyc;
      logic [10:0] cyc_rem;
      logic [5:0]  wk_sum;
      logic        write_date;
   } stage_a_type;

   typedef struct packed {
      logic [4:0]  hours;
      logic [5:0]  minutes;
      logic [15:0] msm;
      logic [7:0]  yr;
      logic [8:0]  doy;
      logic [2:0]  wk;
      logic        write_date;
   } stage_b_type;

   function automatic logic [19:0] hour_split(input logic [19:0] x);
      logic [19:0] r;
      logic [4:0]  q;
      r = x;
      q = '0;
      for (int k = 4; k >= 0; k--) begin
         q = {q[3:0], 1'b0};
         if (r >= (HOUR_DIV << k)) begin
            r    = r - (HOUR_DIV << k);
            q[0] = 1'b1;
         end
      end
      return {q, r[14:0]};
   endfunction

   function automatic logic [16:0] split_q6(input logic [16:0] x, input logic [16:0] divisor);
      logic [16:0] r;
      logic [5:0]  q;
      r = x;
      q = '0;
      for (int k = 5; k >= 0; k--) begin
         q = {q[4:0], 1'b0};
         if (r >= (divisor << k)) begin
            r    = r - (divisor << k);
            q[0] = 1'b1;
         end
      end
      return {q, r[10:0]};
   endfunction

   function automatic logic [12:0] sec_split(input logic [12:0] x);
      logic [12:0] r;
      logic [5:0]  q;
      r = x;
      q = '0;
      for (int k = 5; k >= 0; k--) begin
         q = {q[4:0], 1'b0};
         if (r >= (SEC_DIV << k)) begin
            r    = r - (SEC_DIV << k);
            q[0] = 1'b1;
         end
      end
      return {q, r[6:0]};
   endfunction

   stage_a_type  a_in, a_ff;
   stage_b_type  b_in, b_ff;
   emrc_civ_type c_in, c_ff;
   logic [2:0]   valid_in, valid_ff;
   logic [3:0]   adv;

   logic [19:0] hsplit;
   logic [16:0] zday;
   logic [16:0] csplit;
   logic [16:0] msplit;
   logic [1:0]  yoc;
   logic [10:0] yoff;
   logic [3:0]  wk_fold;
   logic [12:0] ssplit;
   logic [3:0]  mp;
   logic [8:0]  mstart;

   // hour of day, 4-year cycle of the March-based calendar, weekday digit sum
   always_comb begin
      hsplit    = hour_split({in_beat.msd_rem, in_beat.ms_low[9:7]});
      a_in.hours = hsplit[19:15];
      a_in.msh   = {hsplit[14:0], in_beat.ms_low[6:0]};
      zday = {1'b0, in_beat.days} + EPOCH_OFFSET;
      // skip the missing leap day of 2100
      if (zday >= GAP_DAY) begin
         zday = zday + 17'd1;
      end
      csplit       = split_q6(zday, CYCLE_DIV);
      a_in.cyc     = csplit[16:11];
      a_in.cyc_rem = csplit[10:0];
      a_in.wk_sum  = 6'(in_beat.days[2:0]) + 6'(in_beat.days[5:3]) + 6'(in_beat.days[8:6])
                   + 6'(in_beat.days[11:9]) + 6'(in_beat.days[14:12])
                   + 6'(in_beat.days[15]) + WEEK_SHIFT;
      a_in.write_date = in_beat.write_date;
   end

   // minutes, year within cycle, weekday reduce
   always_comb begin
      msplit       = split_q6(a_ff.msh[21:5], MIN_DIV);
      b_in.hours   = a_ff.hours;
      b_in.minutes = msplit[16:11];
      b_in.msm     = {msplit[10:0], a_ff.msh[4:0]};
      if (a_ff.cyc_rem >= YEAR3_DAYS) begin
         yoc  = 2'd3;
         yoff = YEAR3_DAYS;
      end else if (a_ff.cyc_rem >= YEAR2_DAYS) begin
         yoc  = 2'd2;
         yoff = YEAR2_DAYS;
      end else if (a_ff.cyc_rem >= YEAR1_DAYS) begin
         yoc  = 2'd1;
         yoff = YEAR1_DAYS;
      end else begin
         yoc  = 2'd0;
         yoff = '0;
      end
      b_in.doy = 9'(a_ff.cyc_rem - yoff);
      b_in.yr  = {a_ff.cyc, 2'b00} + 8'(yoc);
      wk_fold  = 4'(a_ff.wk_sum[5:3]) + 4'(a_ff.wk_sum[2:0]);
      if (wk_fold >= WEEK_LEN) begin
         wk_fold = wk_fold - WEEK_LEN;
      end
      b_in.wk = wk_fold[2:0];
      b_in.write_date = a_ff.write_date;
   end

   // seconds, milliseconds, month, day, year and weekday
   always_comb begin
      ssplit                = sec_split(b_ff.msm[15:3]);
      c_in.hours            = b_ff.hours;
      c_in.minutes          = b_ff.minutes;
      c_in.seconds_plus_one = ssplit[12:7] + 6'd1;
      c_in.ms               = {ssplit[6:0], b_ff.msm[2:0]};
      mp = '0;
      for (int i = 1; i < 12; i++) begin
         if (b_ff.doy >= MONTH_START[i]) begin
            mp = mp + 4'd1;
         end
      end
      mstart            = MONTH_START[mp];
      c_in.day_of_month = 5'(b_ff.doy - mstart + 9'd1);
      if (mp >= MP_JANUARY) begin
         c_in.month            = mp - 4'd9;
         c_in.years_since_1970 = b_ff.yr + 8'd1 - YEAR_BIAS;
      end else begin
         c_in.month            = mp + 4'd3;
         c_in.years_since_1970 = b_ff.yr - YEAR_BIAS;
      end
      c_in.weekday    = b_ff.wk + 3'd1;
      c_in.write_date = b_ff.write_date;
   end

   assign adv[3] = out_ready;
   for (genvar s = 0; s < 3; s++) begin : g_adv
      assign adv[s] = !valid_ff[s] || adv[s+1];
   end

   assign valid_in = (adv[2:0] & {valid_ff[1:0], in_valid}) | (~adv[2:0] & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         a_ff <= a_in;
      end
      if (adv[1]) begin
         b_ff <= b_in;
      end
      if (adv[2]) begin
         c_ff <= c_in;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[2];
   assign out_beat  = c_ff;

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_beat.hours <= 5'd23) && (out_beat.minutes <= 6'd59)
                 && (out_beat.seconds_plus_one != 6'd0) && (out_beat.seconds_plus_one <= 6'd60)
                 && (out_beat.ms <= 10'd999))
      else $error("time of day out of range");

endmodule

[hdl/emrc_subsec.sv]
`timescale 1ns / 1ps
module emrc_subsec import emrc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [PRESCALER_W-1:0] prescaler,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  emrc_civ_type           in_beat,
   output logic                   out_valid,
   input  logic                   out_ready,
   output emrc_full_type          out_beat
);

   localparam int STEPS = 8;
   localparam logic [7:0] SUB_DIV = 8'd125;
   localparam logic [9:0] MS_MAX  = 10'd999;

   typedef struct packed {
      logic [6:0]  rem;
      logic [15:0] dvd;
      logic [14:0] quo;
   } div_type;

   typedef struct packed {
      emrc_civ_type civ;
      logic [24:0]  product;
   } stage_d_type;

   typedef struct packed {
      emrc_civ_type civ;
      div_type      div;
   } stage_q_type;

   function automatic div_type sub_steps(input div_type x);
      div_type    y;
      logic [7:0] trial;
      y = x;
      for (int k = 0; k < STEPS; k++) begin
         trial = {y.rem, y.dvd[15]};
         y.dvd = {y.dvd[14:0], 1'b0};
         if (trial >= SUB_DIV) begin
            trial = trial - SUB_DIV;
            y.quo = {y.quo[13:0], 1'b1};
         end else begin
            y.quo = {y.quo[13:0], 1'b0};
         end
         y.rem = trial[6:0];
      end
      return y;
   endfunction

   stage_d_type d_in, d_ff;
   stage_q_type e_in, e_ff;
   stage_q_type f_in, f_ff;
   div_type     e_start;
   logic [25:0] product_full;
   logic [2:0]  valid_in, valid_ff;
   logic [3:0]  adv;

   always_comb begin
      product_full = 26'(MS_MAX - in_beat.ms) * 26'({1'b0, prescaler} + 16'd1);
      d_in.civ     = in_beat;
      d_in.product = product_full[24:0];
   end

   // product / 1000 as (product >> 3) / 125
   always_comb begin
      e_start.rem = {1'b0, d_ff.product[24:19]};
      e_start.dvd = d_ff.product[18:3];
      e_start.quo = '0;
      e_in.civ    = d_ff.civ;
      e_in.div    = sub_steps(e_start);
      f_in.civ    = e_ff.civ;
      f_in.div    = sub_steps(e_ff.div);
   end

   assign adv[3] = out_ready;
   for (genvar s = 0; s < 3; s++) begin : g_adv
      assign adv[s] = !valid_ff[s] || adv[s+1];
   end

   assign valid_in = (adv[2:0] & {valid_ff[1:0], in_valid}) | (~adv[2:0] & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         d_ff <= d_in;
      end
      if (adv[1]) begin
         e_ff <= e_in;
      end
      if (adv[2]) begin
         f_ff <= f_in;
      end
   end

   assign in_ready             = adv[0];
   assign out_valid            = valid_ff[2];
   assign out_beat.civ         = f_ff.civ;
   assign out_beat.shift_count = f_ff.div.quo;

endmodule

[hdl/epoch_ms_to_rtc_calendar_core.sv]
`timescale 1ns / 1ps
// Unix epoch milliseconds to calendar RTC load fields (UTC).
// req channel: one beat carries timestamp_ms and write_date; it is taken on a
// clock edge where req_valid and req_ready are both high.
// rsp channel: one beat per request, in order: time of day, seconds plus one,
// subsecond shift count, and the date fields when write_date was set (zero
// otherwise, with date_valid low).
// csr channel: csr_data loads the 15-bit synchronous prescaler; csr_ready is
// always high. Write it only while no request is in flight.
// Pipeline: ten register stages lie between taking a request and rsp_valid.
// Throughput: one beat per cycle while rsp_ready is high, set by the ten-stage
// pipeline of restoring divide steps (four stages for the day split, three for
// time of day and calendar, three for the prescaler multiply and divide).
// Reset: all stages empty, prescaler back to 255.
// Stall: when rsp_ready is low the last stage holds; earlier stages keep
// filling bubbles, and req_ready drops only once all ten stages hold a beat.
module epoch_ms_to_rtc_calendar_core import emrc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  emrc_req_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output emrc_rsp_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [PRESCALER_W-1:0] csr_data
);

   logic [PRESCALER_W-1:0] prescaler_in, prescaler_ff;

   logic          div_valid, div_ready;
   emrc_days_type div_beat;
   logic          civ_valid, civ_ready;
   emrc_civ_type  civ_beat;
   emrc_full_type full_beat;

   assign csr_ready    = 1'b1;
   assign prescaler_in = (csr_valid && csr_ready) ? csr_data : prescaler_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prescaler_ff <= PRESCALER_RESET;
      end else begin
         prescaler_ff <= prescaler_in;
      end
   end

   emrc_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_beat   (req_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_beat  (div_beat)
   );

   emrc_civil u_civil (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_beat   (div_beat),
      .out_valid (civ_valid),
      .out_ready (civ_ready),
      .out_beat  (civ_beat)
   );

   emrc_subsec u_subsec (
      .clock     (clock),
      .reset     (reset),
      .prescaler (prescaler_ff),
      .in_valid  (civ_valid),
      .in_ready  (civ_ready),
      .in_beat   (civ_beat),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_beat  (full_beat)
   );

   // drop the date fields unless the date is to be loaded
   always_comb begin
      rsp_data.hours            = full_beat.civ.hours;
      rsp_data.minutes          = full_beat.civ.minutes;
      rsp_data.seconds_plus_one = full_beat.civ.seconds_plus_one;
      rsp_data.shift_count      = full_beat.shift_count;
      rsp_data.date_valid       = full_beat.civ.write_date;
      if (full_beat.civ.write_date) begin
         rsp_data.weekday          = full_beat.civ.weekday;
         rsp_data.month            = full_beat.civ.month;
         rsp_data.day_of_month     = full_beat.civ.day_of_month;
         rsp_data.years_since_1970 = full_beat.civ.years_since_1970;
      end else begin
         rsp_data.weekday          = '0;
         rsp_data.month            = '0;
         rsp_data.day_of_month     = '0;
         rsp_data.years_since_1970 = '0;
      end
   end

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.date_valid |->
         (rsp_data.weekday != 3'd0) && (rsp_data.month != 4'd0) && (rsp_data.month <= 4'd12)
         && (rsp_data.day_of_month != 5'd0) && (rsp_data.years_since_1970 <= 8'd139))
      else $error("date field out of range");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.shift_count <= 15'd32735))
      else $error("shift count out of range");

   a_prescaler_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_valid |=> (prescaler_ff == $past(prescaler_ff)))
      else $error("prescaler changed without a write");

endmodule
